/* hw/rtl/mhic_pkg.sv */
// Shared types, widths and register indexes for the magnetometer hard-iron calibration unit.
`timescale 1ns / 1ps
`default_nettype none

package mhic_pkg;

	// Field widths fixed by the interface.
	localparam int RAW_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int MAG_W    = 16;
	localparam int TIME_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_AXES = 3;

	// Signed product of a raw reading and a zero-extended gain.
	localparam int PROD_W = RAW_W + GAIN_W + 1;

	// Defaults for the parameters and the configuration registers.
	localparam int AXES_DEFAULT      = 3;
	localparam int GAIN_FRAC_DEFAULT = 12;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;
	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd30000000;

	// Saturation limits of a magnetometer value.
	localparam logic signed [MAG_W-1:0] MAG_MAX = 16'sh7fff;
	localparam logic signed [MAG_W-1:0] MAG_MIN = 16'sh8000;

	// Configuration register indexes.
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_GAIN_X = 2'd0;
	localparam cfg_index_t CFG_GAIN_Y = 2'd1;
	localparam cfg_index_t CFG_GAIN_Z = 2'd2;
	localparam cfg_index_t CFG_WINDOW = 2'd3;

	// Per-word decision from the window controller, shared by every axis lane.
	typedef struct packed {
		logic pass;      // calibrating: scaled value goes out without the offset
		logic first;     // first word of a window: min and max are loaded
		logic update;    // inside the window: min, max and offset follow this word
		logic cal_after; // calibration still running after this word
		logic led_after; // LED state after this word
	} ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/magnetometer_hard_iron_calibration_unit.sv */
// Top level of the magnetometer hard-iron calibration unit.
// An accepted input word is multiplied into stage one, then updated into the output register.
// Throughput: one word per cycle while the output is not stalled; the offset loop closes within
// stage two, set by the subtract, compare and midpoint add of each axis lane.
// Reset clears the configuration to its defaults, the offsets, extremes and window state.
// A stalled result word stalls the input only once stage one also holds a word.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_hard_iron_calibration_unit #(
	parameter int AXES           = mhic_pkg::AXES_DEFAULT,
	parameter int GAIN_FRAC_BITS = mhic_pkg::GAIN_FRAC_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [mhic_pkg::RAW_W-1:0]   raw_x,
	input  wire logic signed [mhic_pkg::RAW_W-1:0]   raw_y,
	input  wire logic signed [mhic_pkg::RAW_W-1:0]   raw_z,
	input  wire logic [mhic_pkg::TIME_W-1:0]         sample_time,
	input  wire logic                                begin_calibration,
	// Output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [mhic_pkg::MAG_W-1:0]        mag_x,
	output logic signed [mhic_pkg::MAG_W-1:0]        mag_y,
	output logic signed [mhic_pkg::MAG_W-1:0]        mag_z,
	output logic                                     in_calibration,
	output logic                                     led_on,
	// Configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mhic_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mhic_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mhic_pkg::*;

	logic                     valid_s1;
	logic                     out_valid_q;
	logic                     out_free;
	logic                     load_s1;
	logic                     commit;
	logic                     cfg_we;
	logic [GAIN_W-1:0]        gain_q [AXES];
	logic [TIME_W-1:0]        window_q;
	logic signed [RAW_W-1:0]  raw_in [MAX_AXES];
	logic signed [MAG_W-1:0]  mag_lane [MAX_AXES];
	logic signed [MAG_W-1:0]  mag_q [MAX_AXES];
	logic                     in_cal_q, led_q;
	ctl_t                     ctl;

	// Handshake: stage one moves on when the output register is free or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign load_s1  = !valid_s1 || out_free;
	assign commit   = valid_s1 && out_free;
	assign in_stall = !load_s1;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we && cfg_index == CFG_WINDOW) begin
			window_q <= cfg_data;
		end
	end

	assign raw_in[0] = raw_x;
	assign raw_in[1] = raw_y;
	assign raw_in[2] = raw_z;

	// Window controller shared by all lanes.
	mhic_window_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.load_s1           (load_s1 && in_valid),
		.commit            (commit),
		.sample_time       (sample_time),
		.begin_calibration (begin_calibration),
		.cal_window        (window_q),
		.ctl               (ctl)
	);

	// One lane per configured axis; absent axes read as zero.
	for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
		if (i < AXES) begin : g_lane
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					gain_q[i] <= GAIN_RESET;
				end else if (cfg_we && cfg_index == cfg_index_t'(CFG_GAIN_X + i)) begin
					gain_q[i] <= cfg_data[GAIN_W-1:0];
				end
			end

			mhic_lane #(
				.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.load_s1 (load_s1 && in_valid),
				.commit  (commit),
				.raw     (raw_in[i]),
				.gain    (gain_q[i]),
				.ctl     (ctl),
				.mag     (mag_lane[i])
			);
		end else begin : g_absent
			assign mag_lane[i] = '0;
		end
	end

	// Merge stage: output register collects the lane values and the status flags.
	always_ff @(posedge clk) begin
		if (commit) begin
			mag_q[0] <= mag_lane[0];
			mag_q[1] <= mag_lane[1];
			mag_q[2] <= mag_lane[2];
			in_cal_q <= ctl.cal_after;
			led_q    <= ctl.led_after;
		end
	end

	assign out_valid      = out_valid_q;
	assign mag_x          = mag_q[0];
	assign mag_y          = mag_q[1];
	assign mag_z          = mag_q[2];
	assign in_calibration = in_cal_q;
	assign led_on         = led_q;

endmodule

`default_nettype wire

/* hw/rtl/mhic_lane.sv */
// One axis lane: gain multiply, saturation, offset removal and min/max tracking.
`timescale 1ns / 1ps
`default_nettype none

module mhic_lane #(
	parameter int GAIN_FRAC_BITS = mhic_pkg::GAIN_FRAC_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load_s1,
	input  wire logic                             commit,
	input  wire logic signed [mhic_pkg::RAW_W-1:0]  raw,
	input  wire logic [mhic_pkg::GAIN_W-1:0]        gain,
	input  wire mhic_pkg::ctl_t                     ctl,
	output logic signed [mhic_pkg::MAG_W-1:0]       mag
);
	import mhic_pkg::*;

	logic signed [PROD_W-1:0] product_s1;
	logic signed [PROD_W-1:0] shifted;
	logic [PROD_W-MAG_W:0]    top_bits;
	logic signed [MAG_W-1:0]  scaled;
	logic signed [MAG_W:0]    diff;
	logic signed [MAG_W-1:0]  min_q, max_q, offset_q;
	logic signed [MAG_W-1:0]  min_next, max_next;
	logic signed [MAG_W:0]    mid_sum;

	// Stage one: signed reading times unsigned gain.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			product_s1 <= PROD_W'(raw) * $signed({1'b0, gain});
		end
	end

	// Floor shift by the fraction bits, then saturate to the value width.
	always_comb begin
		shifted  = product_s1 >>> GAIN_FRAC_BITS;
		top_bits = shifted[PROD_W-1:MAG_W-1];
		if (&top_bits || ~|top_bits) begin
			scaled = shifted[MAG_W-1:0];
		end else if (shifted[PROD_W-1]) begin
			scaled = MAG_MIN;
		end else begin
			scaled = MAG_MAX;
		end
	end

	// Output value: pass-through while calibrating, else offset removed with saturation.
	always_comb begin
		diff = {scaled[MAG_W-1], scaled} - {offset_q[MAG_W-1], offset_q};
		if (ctl.pass) begin
			mag = scaled;
		end else if (diff[MAG_W] != diff[MAG_W-1]) begin
			mag = diff[MAG_W] ? MAG_MIN : MAG_MAX;
		end else begin
			mag = diff[MAG_W-1:0];
		end
	end

	// Extremes after this word; the first word of a window loads both.
	always_comb begin
		if (ctl.first || scaled < min_q) begin
			min_next = scaled;
		end else begin
			min_next = min_q;
		end
		if (ctl.first || scaled > max_q) begin
			max_next = scaled;
		end else begin
			max_next = max_q;
		end
		mid_sum = {min_next[MAG_W-1], min_next} + {max_next[MAG_W-1], max_next};
	end

	// Hard-iron state: extremes and their floored midpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= '0;
			offset_q <= '0;
		end else if (commit && ctl.update) begin
			min_q    <= min_next;
			max_q    <= max_next;
			offset_q <= mid_sum[MAG_W:1];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mhic_window_ctrl.sv */
// Calibration window controller: mode flag, window start, LED and per-word decision.
`timescale 1ns / 1ps
`default_nettype none

module mhic_window_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load_s1,
	input  wire logic                          commit,
	input  wire logic [mhic_pkg::TIME_W-1:0]   sample_time,
	input  wire logic                          begin_calibration,
	input  wire logic [mhic_pkg::TIME_W-1:0]   cal_window,
	output mhic_pkg::ctl_t                     ctl
);
	import mhic_pkg::*;

	logic [TIME_W-1:0] time_s1;
	logic              begin_s1;
	logic              cal_q, start_valid_q, led_q;
	logic [TIME_W-1:0] window_start_q;
	logic              cal_now;
	logic [TIME_W-1:0] start_now;
	logic [TIME_W-1:0] elapsed;
	logic              in_window;

	// Stage one copies of the timing fields.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			time_s1  <= sample_time;
			begin_s1 <= begin_calibration;
		end
	end

	// Decision for the word in stage two.
	always_comb begin
		cal_now   = cal_q || begin_s1;
		start_now = start_valid_q ? window_start_q : time_s1;
		elapsed   = time_s1 - start_now;
		in_window = elapsed < cal_window;

		ctl.pass      = cal_now;
		ctl.first     = !start_valid_q;
		ctl.update    = cal_now && in_window;
		ctl.cal_after = cal_now && in_window;
		if (!cal_now) begin
			ctl.led_after = led_q;
		end else if (in_window) begin
			ctl.led_after = !led_q;
		end else begin
			ctl.led_after = 1'b0;
		end
	end

	// Mode, window start and LED state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q          <= 1'b0;
			start_valid_q  <= 1'b0;
			led_q          <= 1'b0;
			window_start_q <= '0;
		end else if (commit && cal_now) begin
			cal_q          <= in_window;
			start_valid_q  <= in_window;
			led_q          <= ctl.led_after;
			window_start_q <= start_now;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mhic_checker.sv */
// Port-level checks for the magnetometer hard-iron calibration unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mhic_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] mag_x,
	input wire logic        in_calibration,
	input wire logic        led_on
);

	// The LED can only be lit while calibration is running.
	a_led_needs_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!led_on || in_calibration))
		else $error("LED lit outside calibration");

	// A fresh result word comes from an accepted input word that passed through stage one and the output register.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without an accepted input word");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mag_x)))
		else $error("stalled result word changed");

endmodule

bind magnetometer_hard_iron_calibration_unit mhic_checker u_mhic_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.mag_x          (mag_x),
	.in_calibration (in_calibration),
	.led_on         (led_on)
);

`default_nettype wire
